### src/quoted_word_tokenizer_core_defines.svh
// Assertion helpers for the tokenizer core RTL
`ifndef QUOTED_WORD_TOKENIZER_CORE_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define QWT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define QWT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/qwt_pkg.sv
package qwt_pkg;

   localparam int MaxResults = 3;
   localparam int CountW     = 2;

   localparam logic [7:0] ChNul       = 8'h00;
   localparam logic [7:0] ChSpace     = 8'h20;
   localparam logic [7:0] ChSingle    = 8'h27;
   localparam logic [7:0] ChDouble    = 8'h22;
   localparam logic [7:0] ChBackslash = 8'h5C;

   localparam logic [6:0] MaxTokensReset = 7'd64;

   typedef enum logic [1:0] {
      KindChar = 2'd0,
      KindEnd  = 2'd1,
      KindOk   = 2'd2,
      KindErr  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      QuoteNone   = 2'd0,
      QuoteSingle = 2'd1,
      QuoteDouble = 2'd2
   } quote_type;

   typedef struct packed {
      logic       escape_pending;
      quote_type  quote_kind;
      logic       token_open;
      logic [6:0] tokens_done;
      logic       line_stopped;
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] token_char;
      logic [5:0] token_index;
      logic [6:0] token_count;
      logic       last;
   } result_type;

   function automatic result_type make_result(kind_type k, logic [7:0] c,
                                              logic [5:0] idx, logic [6:0] cnt);
      result_type r;
      r.kind        = k;
      r.token_char  = c;
      r.token_index = idx;
      r.token_count = cnt;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

### src/qwt_step.sv
module qwt_step (
   input  qwt_pkg::state_type                          state_cur,
   input  logic [7:0]                                  ch,
   input  logic                                        end_of_line,
   input  logic [6:0]                                  limit,
   output qwt_pkg::state_type                          state_nxt,
   output qwt_pkg::result_type [qwt_pkg::MaxResults-1:0] res,
   output logic [qwt_pkg::CountW-1:0]                  res_cnt
);
   import qwt_pkg::*;

   always_comb begin
      state_type          st;
      logic [CountW-1:0]  n;
      logic               literal;
      quote_type          qc;

      st      = state_cur;
      res     = '0;
      n       = '0;
      literal = 1'b0;

      case (ch)
         ChSingle: qc = QuoteSingle;
         ChDouble: qc = QuoteDouble;
         default:  qc = QuoteNone;
      endcase

      if (!st.line_stopped) begin
         if (ch == ChNul) begin
            st.line_stopped = 1'b1;
         end else begin
            literal = 1'b1;
            if (!st.escape_pending) begin
               if (ch == ChBackslash) begin
                  st.escape_pending = 1'b1;
                  literal           = 1'b0;
               end else if (st.quote_kind != QuoteNone) begin
                  if (qc == st.quote_kind) begin
                     st.quote_kind = QuoteNone;
                     literal       = 1'b0;
                  end
               end else if (ch == ChSpace) begin
                  if (st.token_open) begin
                     res[n]         = make_result(KindEnd, 8'h00, st.tokens_done[5:0], 7'd0);
                     n              = n + 1'b1;
                     st.token_open  = 1'b0;
                     st.tokens_done = st.tokens_done + 7'd1;
                  end
                  literal = 1'b0;
               end else if (qc != QuoteNone) begin
                  st.quote_kind = qc;
                  literal       = 1'b0;
               end
            end
            if (literal) begin
               // a fresh token past the limit stops the line
               if (!st.token_open && st.tokens_done >= limit) begin
                  st.line_stopped = 1'b1;
               end else begin
                  st.token_open     = 1'b1;
                  res[n]            = make_result(KindChar, ch, st.tokens_done[5:0], 7'd0);
                  n                 = n + 1'b1;
                  st.escape_pending = 1'b0;
               end
            end
         end
      end

      if (end_of_line) begin
         if (st.token_open) begin
            res[n]         = make_result(KindEnd, 8'h00, st.tokens_done[5:0], 7'd0);
            n              = n + 1'b1;
            st.tokens_done = st.tokens_done + 7'd1;
         end
         if (st.quote_kind != QuoteNone || st.escape_pending) begin
            res[n] = make_result(KindErr, 8'h00, 6'd0, 7'd0);
         end else begin
            res[n] = make_result(KindOk, 8'h00, 6'd0, st.tokens_done);
         end
         n  = n + 1'b1;
         st = '0;
      end

      if (n != '0) begin
         res[n - 1'b1].last = 1'b1;
      end

      state_nxt = st;
      res_cnt   = n;
   end

endmodule

### src/quoted_word_tokenizer_core.sv
// Shell-style word tokenizer, one line character per req beat. Characters
// pass through an input register, a single step of decode logic and into a
// result register holding every result the character causes (a token
// character, a token end and a line status, three at most). The rsp port
// sends one result per cycle while rsp_ready is high, so a character giving
// at most one result sustains one character per cycle; a character that
// gives more results holds the result port until its last one is taken. The
// first rsp beat of a character leaves the result register, after the input
// register. Write csr_max_tokens only while no line characters are in flight
// and all results have been taken.
module quoted_word_tokenizer_core #(
   parameter int TOKEN_LIMIT = 64
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_max_tokens,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_line,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_token_char,
   output logic [5:0] rsp_token_index,
   output logic [6:0] rsp_token_count,
   output logic       rsp_last
);
   import qwt_pkg::*;
   `include "quoted_word_tokenizer_core_defines.svh"

   logic [6:0]  max_tokens_ff;
   logic [6:0]  limit;

   logic        in_valid_ff;
   logic [7:0]  in_ch_ff;
   logic        in_eol_ff;

   state_type   state_ff;
   state_type   state_nxt;

   result_type [MaxResults-1:0] step_res;
   logic [CountW-1:0]           step_cnt;

   result_type [MaxResults-1:0] bundle_ff;
   result_type [MaxResults-1:0] bundle_in;
   logic [CountW-1:0]           cnt_ff;
   logic [CountW-1:0]           cnt_in;

   logic        pop;
   logic        bundle_free;
   logic        load;

   logic        status_beat;
   logic        line_idle;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tokens_ff <= MaxTokensReset;
      end else if (csr_valid && csr_ready) begin
         max_tokens_ff <= csr_max_tokens;
      end
   end

   assign limit = (int'(max_tokens_ff) < TOKEN_LIMIT) ? max_tokens_ff : 7'(TOKEN_LIMIT);

   qwt_step u_step (
      .state_cur   (state_ff),
      .ch          (in_ch_ff),
      .end_of_line (in_eol_ff),
      .limit       (limit),
      .state_nxt   (state_nxt),
      .res         (step_res),
      .res_cnt     (step_cnt)
   );

   assign rsp_valid   = (cnt_ff != '0);
   assign pop         = rsp_valid && rsp_ready;
   // the bundle takes a new item once its final result goes out
   assign bundle_free = (cnt_ff == '0) || (cnt_ff == CountW'(1) && pop);
   assign load        = in_valid_ff && bundle_free;
   assign req_ready   = !in_valid_ff || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff  <= req_ch;
         in_eol_ff <= req_end_of_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (load) begin
         state_ff <= state_nxt;
      end
   end

   always_comb begin
      bundle_in = bundle_ff;
      cnt_in    = cnt_ff;
      if (load) begin
         bundle_in = step_res;
         cnt_in    = step_cnt;
      end else if (pop) begin
         // advance to the next pending result
         for (int i = 0; i < MaxResults - 1; i++) begin
            bundle_in[i] = bundle_ff[i + 1];
         end
         bundle_in[MaxResults-1] = '0;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

   assign rsp_kind        = bundle_ff[0].kind;
   assign rsp_token_char  = bundle_ff[0].token_char;
   assign rsp_token_index = bundle_ff[0].token_index;
   assign rsp_token_count = bundle_ff[0].token_count;
   assign rsp_last        = bundle_ff[0].last;

   assign status_beat = (bundle_ff[0].kind == KindOk) || (bundle_ff[0].kind == KindErr);
   assign line_idle   = (state_ff.tokens_done == 7'd0) && !state_ff.token_open &&
                        !state_ff.line_stopped;

   `QWT_ASSERT_NOW(a_last_is_final, rsp_valid && rsp_last, cnt_ff == CountW'(1), "last not final")
   `QWT_ASSERT_NOW(a_status_is_last, rsp_valid && status_beat, rsp_last, "status without last")
   `QWT_ASSERT_NEXT(a_eol_clears, load && in_eol_ff, line_idle, "line state not cleared")

endmodule
